@@ hw/rtl/index_pool_with_free_list_assert.svh @@
// assertion macros for the index pool
`ifndef INDEX_POOL_WITH_FREE_LIST_ASSERT_SVH
`define INDEX_POOL_WITH_FREE_LIST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ipf_pkg.sv @@
// constants and codes shared by the index pool files
package ipf_pkg;

  localparam int DEPTH       = 256;
  localparam int ORIGIN_BITS = 32;

  localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = IDX_BITS + 1;
  localparam int CMP_BITS   = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  localparam int FUNC_BITS   = 3;
  localparam int IN_ORG_BITS = 32;
  localparam int SLOT_BITS   = 8;
  localparam int RES_BITS    = 8;
  localparam int STAT_BITS   = 2;

  localparam logic [FUNC_BITS-1:0] FN_ADD_DEDUP  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_ADD_UNIQUE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_ADD_DISP   = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_REMOVE     = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_LAST_INDEX = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD   = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd3;

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [ORIGIN_BITS-1:0] origin_t;

endpackage

@@ hw/rtl/ipf_in_if.sv @@
// request channel: operation, origin value and slot
interface ipf_in_if;
  import ipf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FUNC_BITS-1:0]   func;
  logic [IN_ORG_BITS-1:0] origin;
  logic [SLOT_BITS-1:0]   slot;

  modport source (output valid, func, origin, slot, input ready);
  modport sink   (input valid, func, origin, slot, output ready);
endinterface

@@ hw/rtl/ipf_out_if.sv @@
// result channel: reported index and status
interface ipf_out_if;
  import ipf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RES_BITS-1:0]  result_index;
  logic [STAT_BITS-1:0] status;

  modport source (output valid, result_index, status, input ready);
  modport sink   (input valid, result_index, status, output ready);
endinterface

@@ hw/rtl/index_pool_with_free_list.sv @@
// index pool: origin table with append count and lifo free list
//
// in_ch carries one request: func selects add dedup, add unique, add
// disposable, remove or last index; origin is the value to store and slot
// the index to release. out_ch returns one item per request with
// result_index and status (ok, full, bad index, empty).
// In the accept cycle (idle state) the rams read the table entry at the
// last index and the top of the free list; then, in the work state, the
// block decides, writes at most one table entry and at most one stack
// entry and loads the result register. The registered read of the two
// rams is why the decision waits for the work state, and a new item is
// not taken until the work state has finished the last one.
// Reset (rst_n low, synchronous) empties the table and the free list at
// once; the rams are not cleared, unwritten entries are never read.
// If out_ch.ready stays low, the finished item waits in the result
// register; a following item is taken and then holds in the work
// state until the register frees up, and in_ch.ready stays low meanwhile.
module index_pool_with_free_list (
  input  logic       clk,
  input  logic       rst_n,
  ipf_in_if.sink     in_ch,
  ipf_out_if.source  out_ch
);
  import ipf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic state_r, state_nxt;
  count_t used_count_r, used_count_nxt;
  count_t free_count_r, free_count_nxt;

  logic [FUNC_BITS-1:0] func_r;
  origin_t              origin_r;
  logic [SLOT_BITS-1:0] slot_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [RES_BITS-1:0]  out_index_r, out_index_nxt;
  logic [STAT_BITS-1:0] out_status_r, out_status_nxt;

  logic    in_take, commit;
  idx_t    last_addr, top_addr;
  origin_t last_rd;
  idx_t    top_rd;

  logic    tbl_we;
  idx_t    tbl_waddr;
  origin_t tbl_wdata;
  logic    stk_we;
  idx_t    stk_waddr;
  idx_t    stk_wdata;

  logic                 used_empty, tbl_full, free_empty, free_full;
  logic [CMP_BITS-1:0]  slot_ext;
  idx_t                 slot_idx;
  idx_t                 res_idx;
  logic [STAT_BITS-1:0] res_status;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign commit   = (state_r == S_WORK) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  assign last_addr = IDX_BITS'(used_count_r - count_t'(1));
  assign top_addr  = IDX_BITS'(free_count_r - count_t'(1));

  ipf_ram #(.WIDTH(ORIGIN_BITS), .DEPTH(DEPTH)) u_origin_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (last_addr),
    .rdata (last_rd)
  );

  ipf_ram #(.WIDTH(IDX_BITS), .DEPTH(DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (top_addr),
    .rdata (top_rd)
  );

  assign used_empty = (used_count_r == '0);
  assign tbl_full   = (used_count_r == COUNT_BITS'(DEPTH));
  assign free_empty = (free_count_r == '0);
  assign free_full  = (free_count_r == COUNT_BITS'(DEPTH));
  assign slot_ext   = CMP_BITS'(slot_r);
  assign slot_idx   = slot_ext[IDX_BITS-1:0];

  always_comb begin
    used_count_nxt = used_count_r;
    free_count_nxt = free_count_r;
    tbl_we         = 1'b0;
    tbl_waddr      = used_count_r[IDX_BITS-1:0];
    tbl_wdata      = origin_r;
    stk_we         = 1'b0;
    stk_waddr      = free_count_r[IDX_BITS-1:0];
    stk_wdata      = slot_idx;
    res_idx        = '0;
    res_status     = ST_OK;

    case (func_r)
      FN_ADD_DEDUP, FN_ADD_UNIQUE: begin
        if (func_r == FN_ADD_DEDUP && !used_empty && last_rd == origin_r) begin
          res_idx = last_addr;
        end else if (!tbl_full) begin
          tbl_we         = 1'b1;
          res_idx        = used_count_r[IDX_BITS-1:0];
          used_count_nxt = used_count_r + count_t'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      FN_ADD_DISP: begin
        if (!free_empty) begin
          tbl_we         = 1'b1;
          tbl_waddr      = top_rd;
          res_idx        = top_rd;
          free_count_nxt = free_count_r - count_t'(1);
        end else if (!tbl_full) begin
          tbl_we         = 1'b1;
          res_idx        = used_count_r[IDX_BITS-1:0];
          used_count_nxt = used_count_r + count_t'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      FN_REMOVE: begin
        if (slot_ext >= CMP_BITS'(used_count_r)) begin
          res_status = ST_BAD;
        end else if (free_full) begin
          res_status = ST_FULL;
        end else begin
          stk_we         = 1'b1;
          tbl_we         = 1'b1;
          tbl_waddr      = slot_idx;
          tbl_wdata      = '0;
          res_idx        = slot_idx;
          free_count_nxt = free_count_r + count_t'(1);
        end
      end
      FN_LAST_INDEX: begin
        if (used_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_idx = last_addr;
        end
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase

    if (!commit) begin
      used_count_nxt = used_count_r;
      free_count_nxt = free_count_r;
      tbl_we         = 1'b0;
      stk_we         = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (commit) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_index_nxt  = (res_status == ST_OK) ? RES_BITS'(res_idx) : '0;
          out_status_nxt = res_status;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      free_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r   <= in_ch.func;
      origin_r <= ORIGIN_BITS'(in_ch.origin);
      slot_r   <= in_ch.slot;
    end
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.status       = out_status_r;

`include "index_pool_with_free_list_assert.svh"

  `IPF_ASSERT_NOW(a_counts_bounded, 1'b1,
    used_count_r <= COUNT_BITS'(DEPTH) && free_count_r <= COUNT_BITS'(DEPTH),
    "count beyond depth")
  `IPF_ASSERT_NOW(a_fail_zero_index, out_valid_r && out_status_r != ST_OK,
    out_index_r == '0, "failed item carries an index")
  `IPF_ASSERT_NEXT(a_accept_to_work, in_take, state_r == S_WORK,
    "accepted item not in work")
  `IPF_ASSERT_NEXT(a_counts_hold, !commit,
    $stable(used_count_r) && $stable(free_count_r), "counts moved without commit")
endmodule

@@ hw/rtl/ipf_ram.sv @@
// generic single-write, single-read ram with registered read
module ipf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
